// ===== sv/aff3inv_pkg.sv =====
package aff3inv_pkg;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned EntryWidth = 32;
  localparam int unsigned NumEntries = 12;
  localparam int unsigned IndexWidth = 4;

endpackage

// ===== sv/affine_3d_inverse.sv =====
// Inverts a 3x4 affine transform (3x3 linear part plus translation column) in signed
// fixed point with saturation. Entries are loaded row-major, one transaction each, one
// cycle apiece; a transaction with final_entry_i set starts the inversion, during which
// in_ready_o is low. The inversion runs 39 multiply terms on one shared
// multiply/round/accumulate datapath plus a restoring reciprocal divider (default format
// Q15.16), then emits the twelve inverse entries row-major, one per cycle when the
// sink is ready. A zero determinant stops early and emits twelve zeros with singular_o set.
// Indexes 12 to 15 are not stored but final_entry_i still starts an inversion.
module affine_3d_inverse #(
  parameter int unsigned FRAC_BITS   = aff3inv_pkg::FracBits,
  parameter int unsigned ENTRY_WIDTH = aff3inv_pkg::EntryWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    entry_index_i,
  input  logic signed [ENTRY_WIDTH-1:0] entry_value_i,
  input  logic                          final_entry_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0]                    out_index_o,
  output logic signed [ENTRY_WIDTH-1:0] out_value_o,
  output logic                          singular_o,
  output logic                          last_of_run_o
);

  localparam int unsigned W  = ENTRY_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned MW = PW - F;
  localparam int unsigned NW = ((2 * F > W - 1) ? 2 * F : W - 1) + 1;
  localparam int unsigned CW = $clog2(NW + 1);

  localparam logic [W-1:0]  SatMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  SatMin = {1'b1, {(W-1){1'b0}}};
  localparam logic [MW-1:0] RndPos = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [MW-1:0] RndNeg = RndPos + MW'(1);
  localparam logic [NW-1:0] DivPos = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NW-1:0] DivNeg = DivPos + NW'(1);
  localparam logic [PW-1:0] RndHalf = PW'(1) << (F - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCalc = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  localparam logic [1:0] KTerm = 2'd0;
  localparam logic [1:0] KJz   = 2'd1;
  localparam logic [1:0] KDiv  = 2'd2;
  localparam logic [1:0] KEnd  = 2'd3;

  localparam logic [1:0] CMov = 2'd0;
  localparam logic [1:0] CAdd = 2'd1;
  localparam logic [1:0] CSub = 2'd2;

  localparam logic [4:0] RInv = 5'd12;
  localparam logic [4:0] RCxx = 5'd24;
  localparam logic [4:0] RCxy = 5'd25;
  localparam logic [4:0] RCxz = 5'd26;
  localparam logic [4:0] RRcp = 5'd27;
  localparam logic [4:0] RTmp = 5'd28;

  localparam logic [3:0] LastIdx = 4'(aff3inv_pkg::NumEntries - 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] src_a;
    logic [4:0] src_b;
    logic [1:0] comb;
    logic       neg;
    logic       st;
    logic [4:0] dst;
  } uop_t;

  function automatic uop_t term(input logic [4:0] a, input logic [4:0] b,
                                input logic [1:0] c, input logic n,
                                input logic s, input logic [4:0] d);
    uop_t u;
    u.kind  = KTerm;
    u.src_a = a;
    u.src_b = b;
    u.comb  = c;
    u.neg   = n;
    u.st    = s;
    u.dst   = d;
    return u;
  endfunction

  function automatic uop_t ctrl(input logic [1:0] k, input logic s, input logic [4:0] d);
    uop_t u;
    u       = '0;
    u.kind  = k;
    u.st    = s;
    u.dst   = d;
    return u;
  endfunction

  // Cofactors, determinant, reciprocal, scaled adjugate, then translation rows.
  function automatic uop_t ucode(input logic [5:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = term(5'd5,  5'd10, CMov, 1'b0, 1'b0, RTmp);
      6'd1:  u = term(5'd6,  5'd9,  CSub, 1'b0, 1'b1, RCxx);
      6'd2:  u = term(5'd4,  5'd10, CMov, 1'b0, 1'b0, RTmp);
      6'd3:  u = term(5'd6,  5'd8,  CSub, 1'b0, 1'b1, RCxy);
      6'd4:  u = term(5'd4,  5'd9,  CMov, 1'b0, 1'b0, RTmp);
      6'd5:  u = term(5'd5,  5'd8,  CSub, 1'b0, 1'b1, RCxz);
      6'd6:  u = term(5'd0,  RCxx,  CMov, 1'b0, 1'b0, RTmp);
      6'd7:  u = term(5'd1,  RCxy,  CSub, 1'b0, 1'b0, RTmp);
      6'd8:  u = term(5'd2,  RCxz,  CAdd, 1'b0, 1'b0, RTmp);
      6'd9:  u = ctrl(KJz, 1'b0, RTmp);
      6'd10: u = ctrl(KDiv, 1'b1, RRcp);
      6'd11: u = term(RCxx,  RRcp,  CMov, 1'b0, 1'b1, 5'd12);
      6'd12: u = term(5'd1,  5'd10, CMov, 1'b0, 1'b0, RTmp);
      6'd13: u = term(5'd2,  5'd9,  CSub, 1'b0, 1'b1, RTmp);
      6'd14: u = term(RTmp,  RRcp,  CMov, 1'b1, 1'b1, 5'd13);
      6'd15: u = term(5'd1,  5'd6,  CMov, 1'b0, 1'b0, RTmp);
      6'd16: u = term(5'd2,  5'd5,  CSub, 1'b0, 1'b1, RTmp);
      6'd17: u = term(RTmp,  RRcp,  CMov, 1'b0, 1'b1, 5'd14);
      6'd18: u = term(RCxy,  RRcp,  CMov, 1'b1, 1'b1, 5'd16);
      6'd19: u = term(5'd0,  5'd10, CMov, 1'b0, 1'b0, RTmp);
      6'd20: u = term(5'd2,  5'd8,  CSub, 1'b0, 1'b1, RTmp);
      6'd21: u = term(RTmp,  RRcp,  CMov, 1'b0, 1'b1, 5'd17);
      6'd22: u = term(5'd0,  5'd6,  CMov, 1'b0, 1'b0, RTmp);
      6'd23: u = term(5'd2,  5'd4,  CSub, 1'b0, 1'b1, RTmp);
      6'd24: u = term(RTmp,  RRcp,  CMov, 1'b1, 1'b1, 5'd18);
      6'd25: u = term(RCxz,  RRcp,  CMov, 1'b0, 1'b1, 5'd20);
      6'd26: u = term(5'd0,  5'd9,  CMov, 1'b0, 1'b0, RTmp);
      6'd27: u = term(5'd1,  5'd8,  CSub, 1'b0, 1'b1, RTmp);
      6'd28: u = term(RTmp,  RRcp,  CMov, 1'b1, 1'b1, 5'd21);
      6'd29: u = term(5'd0,  5'd5,  CMov, 1'b0, 1'b0, RTmp);
      6'd30: u = term(5'd1,  5'd4,  CSub, 1'b0, 1'b1, RTmp);
      6'd31: u = term(RTmp,  RRcp,  CMov, 1'b0, 1'b1, 5'd22);
      6'd32: u = term(5'd12, 5'd3,  CMov, 1'b0, 1'b0, RTmp);
      6'd33: u = term(5'd13, 5'd7,  CAdd, 1'b0, 1'b0, RTmp);
      6'd34: u = term(5'd14, 5'd11, CAdd, 1'b1, 1'b1, 5'd15);
      6'd35: u = term(5'd16, 5'd3,  CMov, 1'b0, 1'b0, RTmp);
      6'd36: u = term(5'd17, 5'd7,  CAdd, 1'b0, 1'b0, RTmp);
      6'd37: u = term(5'd18, 5'd11, CAdd, 1'b1, 1'b1, 5'd19);
      6'd38: u = term(5'd20, 5'd3,  CMov, 1'b0, 1'b0, RTmp);
      6'd39: u = term(5'd21, 5'd7,  CAdd, 1'b0, 1'b0, RTmp);
      6'd40: u = term(5'd22, 5'd11, CAdd, 1'b1, 1'b1, 5'd23);
      default: u = ctrl(KEnd, 1'b0, RTmp);
    endcase
    return u;
  endfunction

  logic [1:0]  state_q;
  logic [5:0]  pc_q;
  logic [2:0]  ph_q;
  logic [3:0]  emit_k_q;
  logic        sing_q;
  logic signed [W-1:0] rf_q [32];
  logic signed [W-1:0] a_q;
  logic signed [W-1:0] acc_q;
  logic signed [W-1:0] q_q;
  logic signed [PW-1:0] prod_q;
  logic [PW-1:0] mag_q;
  logic        rneg_q;
  logic [NW-1:0] div_num_q;
  logic [W:0]    div_rem_q;
  logic [W-1:0]  div_d_q;
  logic          div_neg_q;
  logic [CW-1:0] div_cnt_q;
  logic        out_valid_q;
  logic [3:0]  out_index_q;
  logic signed [W-1:0] out_value_q;
  logic        out_sing_q;
  logic        out_last_q;

  uop_t        uop;
  logic [4:0]  rd_addr;
  logic signed [W-1:0] rd_data;
  logic        p_neg;
  logic [PW-1:0] p_mag;
  logic [MW-1:0] mr, mr_lim, mr_sat;
  logic [W-1:0]  q_val;
  logic [W:0]    sum_add, sum_sub;
  logic [W-1:0]  acc_add, acc_sub, acc_neg;
  logic [W-1:0]  ud;
  logic [W:0]    div_t;
  logic          div_ge;
  logic [NW-1:0] dq_lim, dq_sat;
  logic [W-1:0]  div_res;
  logic          in_fire;
  logic          emit_load;

  assign uop = ucode(pc_q);

  always_comb begin
    rd_addr = uop.src_a;
    if (state_q == StEmit) begin
      rd_addr = RInv + 5'(emit_k_q);
    end else if (ph_q == 3'd1) begin
      rd_addr = uop.src_b;
    end
  end
  assign rd_data = rf_q[rd_addr];

  // Product rounding: half away from zero on the magnitude, then clamp.
  assign p_neg  = prod_q[PW-1];
  assign p_mag  = p_neg ? (~prod_q + PW'(1)) : prod_q;
  assign mr     = mag_q[PW-1:F];
  assign mr_lim = rneg_q ? RndNeg : RndPos;
  assign mr_sat = (mr > mr_lim) ? mr_lim : mr;
  assign q_val  = rneg_q ? (~mr_sat[W-1:0] + W'(1)) : mr_sat[W-1:0];

  assign sum_add = {acc_q[W-1], acc_q} + {q_q[W-1], q_q};
  assign sum_sub = {acc_q[W-1], acc_q} - {q_q[W-1], q_q};
  assign acc_add = (sum_add[W] != sum_add[W-1]) ? (sum_add[W] ? SatMin : SatMax)
                                                : sum_add[W-1:0];
  assign acc_sub = (sum_sub[W] != sum_sub[W-1]) ? (sum_sub[W] ? SatMin : SatMax)
                                                : sum_sub[W-1:0];
  assign acc_neg = (acc_q == SatMin) ? SatMax : (~acc_q + W'(1));

  // Restoring divider for 2^(2F) / |det|, one quotient bit per cycle.
  assign ud      = acc_q[W-1] ? (~acc_q + W'(1)) : acc_q;
  assign div_t   = {div_rem_q[W-1:0], div_num_q[NW-1]};
  assign div_ge  = div_t >= {1'b0, div_d_q};
  assign dq_lim  = div_neg_q ? DivNeg : DivPos;
  assign dq_sat  = (div_num_q > dq_lim) ? dq_lim : div_num_q;
  assign div_res = div_neg_q ? (~dq_sat[W-1:0] + W'(1)) : dq_sat[W-1:0];

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_load  = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pc_q        <= '0;
      ph_q        <= '0;
      emit_k_q    <= '0;
      sing_q      <= 1'b0;
      a_q         <= '0;
      acc_q       <= '0;
      q_q         <= '0;
      prod_q      <= '0;
      mag_q       <= '0;
      rneg_q      <= 1'b0;
      div_num_q   <= '0;
      div_rem_q   <= '0;
      div_d_q     <= '0;
      div_neg_q   <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        rf_q[i] <= '0;
      end
    end else begin
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (entry_index_i <= LastIdx) begin
              rf_q[5'(entry_index_i)] <= entry_value_i;
            end
            if (final_entry_i) begin
              state_q <= StCalc;
              pc_q    <= '0;
              ph_q    <= '0;
              sing_q  <= 1'b0;
            end
          end
        end
        StCalc: begin
          case (uop.kind)
            KTerm: begin
              if (ph_q < 3'd6) begin
                ph_q <= ph_q + 3'd1;
              end
              case (ph_q)
                3'd0: a_q <= rd_data;
                3'd1: prod_q <= a_q * rd_data;
                3'd2: begin
                  rneg_q <= p_neg;
                  mag_q  <= p_mag + RndHalf;
                end
                3'd3: q_q <= q_val;
                3'd4: begin
                  case (uop.comb)
                    CAdd:    acc_q <= acc_add;
                    CSub:    acc_q <= acc_sub;
                    default: acc_q <= q_q;
                  endcase
                end
                3'd5: begin
                  if (uop.neg) begin
                    acc_q <= acc_neg;
                  end
                end
                default: begin
                  if (uop.st) begin
                    rf_q[uop.dst] <= acc_q;
                  end
                  pc_q <= pc_q + 6'd1;
                  ph_q <= '0;
                end
              endcase
            end
            KJz: begin
              if (acc_q == '0) begin
                sing_q   <= 1'b1;
                state_q  <= StEmit;
                emit_k_q <= '0;
              end else begin
                pc_q <= pc_q + 6'd1;
              end
            end
            KDiv: begin
              case (ph_q)
                3'd0: begin
                  div_d_q   <= ud;
                  div_neg_q <= acc_q[W-1];
                  div_num_q <= (NW'(1) << (2 * F)) + NW'(ud >> 1);
                  div_rem_q <= '0;
                  div_cnt_q <= CW'(NW);
                  ph_q      <= 3'd1;
                end
                3'd1: begin
                  div_rem_q <= div_ge ? (div_t - {1'b0, div_d_q}) : div_t;
                  div_num_q <= {div_num_q[NW-2:0], div_ge};
                  div_cnt_q <= div_cnt_q - CW'(1);
                  if (div_cnt_q == CW'(1)) begin
                    ph_q <= 3'd2;
                  end
                end
                3'd2: begin
                  acc_q <= div_res;
                  ph_q  <= 3'd3;
                end
                default: begin
                  if (uop.st) begin
                    rf_q[uop.dst] <= acc_q;
                  end
                  pc_q <= pc_q + 6'd1;
                  ph_q <= '0;
                end
              endcase
            end
            default: begin
              state_q  <= StEmit;
              emit_k_q <= '0;
            end
          endcase
        end
        StEmit: begin
          if (emit_load) begin
            if (emit_k_q == LastIdx) begin
              state_q  <= StIdle;
              emit_k_q <= '0;
            end else begin
              emit_k_q <= emit_k_q + 4'd1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_index_q <= emit_k_q;
      out_value_q <= sing_q ? '0 : rd_data;
      out_sing_q  <= sing_q;
      out_last_q  <= (emit_k_q == LastIdx);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign out_value_o   = out_value_q;
  assign singular_o    = out_sing_q;
  assign last_of_run_o = out_last_q;

`ifndef ASSERT_OFF
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |-> out_index_o == LastIdx)
    else $error("last_of_run on wrong index");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> out_value_o == '0)
    else $error("singular transaction with nonzero value");

  a_emit_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == StEmit) |-> $past(state_q) == StCalc)
    else $error("emission entered without calculation");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load && !(state_q == StEmit && emit_k_q == LastIdx) |=> state_q == StEmit)
    else $error("emission ended early");
`endif

endmodule

// ===== bench/tb_affine_3d_inverse.sv =====
`timescale 1ns / 100ps

module tb_affine_3d_inverse;

  localparam int unsigned EW = aff3inv_pkg::EntryWidth;
  localparam int unsigned FB = aff3inv_pkg::FracBits;
  localparam int unsigned NumEntries = aff3inv_pkg::NumEntries;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic signed [EW-1:0] VMAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] VMIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [EW-1:0] ONE = 1 <<< FB;

  typedef logic signed [EW-1:0] fix_t;

  typedef struct packed {
    logic [3:0] index;
    fix_t       value;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic [3:0] index;
    fix_t       value;
    logic       singular;
    logic       last;
  } inv_entry_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [3:0] entry_index_i = '0;
  fix_t       entry_value_i = '0;
  logic       final_entry_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] out_index_o;
  fix_t       out_value_o;
  logic       singular_o;
  logic       last_of_run_o;

  affine_3d_inverse u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .entry_index_i(entry_index_i), .entry_value_i(entry_value_i),
    .final_entry_i(final_entry_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_index_o(out_index_o), .out_value_o(out_value_o),
    .singular_o(singular_o), .last_of_run_o(last_of_run_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  entry_t     pending_entries[$];
  inv_entry_t expected_inverse[$];
  fix_t       mirror_store[NumEntries];
  int unsigned mismatch_count = 0;
  int unsigned extra_count = 0;
  int unsigned entries_sent = 0;
  int unsigned inversions = 0;
  int unsigned singular_runs = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  bit hold_sender = 1'b0;

  // ---------------- fixed-point predictor ----------------
  function automatic fix_t clamp_wide(logic signed [EW+1:0] v);
    if (v > $signed({{2{1'b0}}, VMAX})) return VMAX;
    if (v < $signed({{2{1'b1}}, VMIN})) return VMIN;
    return v[EW-1:0];
  endfunction

  function automatic fix_t fx_add(fix_t a, fix_t b);
    logic signed [EW+1:0] s;
    s = $signed({{2{a[EW-1]}}, a}) + $signed({{2{b[EW-1]}}, b});
    return clamp_wide(s);
  endfunction

  function automatic fix_t fx_sub(fix_t a, fix_t b);
    logic signed [EW+1:0] s;
    s = $signed({{2{a[EW-1]}}, a}) - $signed({{2{b[EW-1]}}, b});
    return clamp_wide(s);
  endfunction

  function automatic fix_t fx_neg(fix_t a);
    return (a == VMIN) ? VMAX : -a;
  endfunction

  // magnitude to signed, saturating at the limit of the sign
  function automatic fix_t from_magnitude(bit neg, logic [2*EW:0] m);
    logic [2*EW:0] lim;
    lim = neg ? ((2*EW+1)'(1) << (EW-1)) : (((2*EW+1)'(1) << (EW-1)) - 1);
    if (m > lim) m = lim;
    return neg ? fix_t'(-m[EW-1:0]) : fix_t'(m[EW-1:0]);
  endfunction

  function automatic logic [EW:0] mag_of(fix_t a);
    return a[EW-1] ? ((EW+1)'(0) - {a[EW-1], a}) : {1'b0, a};
  endfunction

  // exact product, rounded half away from zero, saturated
  function automatic fix_t fx_mul(fix_t a, fix_t b);
    logic [2*EW:0] p;
    p = mag_of(a) * mag_of(b);
    p = (p + ((2*EW+1)'(1) << (FB-1))) >> FB;
    return from_magnitude(a[EW-1] ^ b[EW-1], p);
  endfunction

  function automatic fix_t fx_recip(fix_t d);
    logic [2*EW:0] num, m;
    m = mag_of(d);
    num = (2*EW+1)'(1) << (2*FB);
    return from_magnitude(d[EW-1], (num + m / 2) / m);
  endfunction

  function automatic fix_t cofactor(fix_t a, fix_t b, fix_t c, fix_t e);
    return fx_sub(fx_mul(a, b), fx_mul(c, e));
  endfunction

  task automatic predict_inverse();
    fix_t t[NumEntries];
    fix_t v[NumEntries];
    fix_t cxx, cxy, cxz, det, r, s;
    bit   sing;
    inv_entry_t res;
    t = mirror_store;
    cxx = cofactor(t[5], t[10], t[6], t[9]);
    cxy = cofactor(t[4], t[10], t[6], t[8]);
    cxz = cofactor(t[4], t[9], t[5], t[8]);
    det = fx_add(fx_sub(fx_mul(t[0], cxx), fx_mul(t[1], cxy)), fx_mul(t[2], cxz));
    sing = (det == 0);
    foreach (v[k]) v[k] = '0;
    if (!sing) begin
      r = fx_recip(det);
      v[0]  = fx_mul(cxx, r);
      v[1]  = fx_neg(fx_mul(cofactor(t[1], t[10], t[2], t[9]), r));
      v[2]  = fx_mul(cofactor(t[1], t[6], t[2], t[5]), r);
      v[4]  = fx_neg(fx_mul(cxy, r));
      v[5]  = fx_mul(cofactor(t[0], t[10], t[2], t[8]), r);
      v[6]  = fx_neg(fx_mul(cofactor(t[0], t[6], t[2], t[4]), r));
      v[8]  = fx_mul(cxz, r);
      v[9]  = fx_neg(fx_mul(cofactor(t[0], t[9], t[1], t[8]), r));
      v[10] = fx_mul(cofactor(t[0], t[5], t[1], t[4]), r);
      for (int row = 0; row < 3; row++) begin
        s = fx_add(fx_mul(v[4*row], t[3]), fx_mul(v[4*row+1], t[7]));
        v[4*row+3] = fx_neg(fx_add(s, fx_mul(v[4*row+2], t[11])));
      end
    end
    for (int k = 0; k < NumEntries; k++) begin
      res.index = 4'(k);
      res.value = v[k];
      res.singular = sing;
      res.last = (k == NumEntries - 1);
      expected_inverse.push_back(res);
    end
    inversions++;
    if (sing) singular_runs++;
  endtask

  // ---------------- stimulus helpers ----------------
  function automatic fix_t rand_entry(int mode);
    case (mode)
      0: return fix_t'($urandom);
      1: return fix_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      default: return fix_t'($signed($urandom_range(0, 1 << (FB + 1))) - ONE);
    endcase
  endfunction

  task automatic queue_entry(int idx, fix_t val, bit fin);
    entry_t e;
    e.index = 4'(idx);
    e.value = val;
    e.last = fin;
    pending_entries.push_back(e);
  endtask

  task automatic queue_transform(fix_t m[NumEntries]);
    for (int k = 0; k < NumEntries; k++) queue_entry(k, m[k], k == NumEntries - 1);
  endtask

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // sampled on the falling edge so driver and monitor updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_entries.size() != 0 || in_valid_i || expected_inverse.size() != 0);
  endtask

  // ---------------- driver ----------------
  int unsigned send_gap = 0;
  bit quiet_sender = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (in_valid_i && entry_index_i < NumEntries)
          mirror_store[entry_index_i] = entry_value_i;
        if (final_entry_i) predict_inverse();
        entries_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0 && !quiet_sender) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_entries.size() > 0 && !hold_sender) begin
          entry_t e;
          e = pending_entries.pop_front();
          in_valid_i <= 1'b1;
          entry_index_i <= e.index;
          entry_value_i <= e.value;
          final_entry_i <= e.last;
          send_gap = quiet_sender ? 0 : short_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int unsigned stall_left = 0;
  bit quiet_sink = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_inverse.size() == 0) begin
          extra_count++;
          if (mismatch_count + extra_count <= 10)
            $display("unexpected inverse entry: index %0d value %h", out_index_o, out_value_o);
        end else begin
          inv_entry_t exp_e;
          exp_e = expected_inverse.pop_front();
          if (exp_e.index !== out_index_o || exp_e.value !== out_value_o ||
              exp_e.singular !== singular_o || exp_e.last !== last_of_run_o) begin
            mismatch_count++;
            if (mismatch_count + extra_count <= 10)
              $display("mismatch: exp idx %0d val %h sing %b last %b / got idx %0d val %h sing %b last %b",
                       exp_e.index, exp_e.value, exp_e.singular, exp_e.last,
                       out_index_o, out_value_o, singular_o, last_of_run_o);
          end
        end
      end
      if (quiet_sink) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = short_gap();
      end
    end
  end

  // watchdog: cycles without any accepted transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("affine_3d_inverse verification failed");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    fix_t m[NumEntries];
    int mode;
    foreach (mirror_store[k]) mirror_store[k] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all-zero store after reset: singular
    queue_entry(0, '0, 1'b1);
    // identity with translation
    foreach (m[k]) m[k] = '0;
    m[0] = ONE; m[5] = ONE; m[10] = ONE; m[3] = 5 <<< FB; m[7] = -3 <<< FB; m[11] = ONE;
    queue_transform(m);
    // out-of-range indexes ignored, final still fires
    queue_entry(12, VMAX, 1'b0);
    queue_entry(15, VMIN, 1'b1);
    // tiny diagonal: products round to zero, so the determinant is zero: singular
    queue_entry(0, fix_t'(1), 1'b0);
    queue_entry(5, fix_t'(1), 1'b0);
    queue_entry(10, fix_t'(1), 1'b1);
    // extremes of the field
    foreach (m[k]) m[k] = (k % 2) ? VMAX : VMIN;
    queue_transform(m);

    // quiet phase: wait for all results, then stream with no gaps
    wait_drained();
    hold_sender = 1'b1;
    repeat (20) @(posedge clk_i);
    quiet_sender = 1'b1;
    quiet_sink = 1'b1;
    hold_sender = 1'b0;
    foreach (m[k]) m[k] = rand_entry(2);
    queue_transform(m);
    wait_drained();
    quiet_sender = 1'b0;
    quiet_sink = 1'b0;

    // random: mostly full transforms, some partial loads and noise
    while (entries_sent + pending_entries.size() < 230) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        foreach (m[k]) m[k] = rand_entry(mode % 3);
        if (mode == 6) m[$urandom_range(0, 2)] = '0;
        queue_transform(m);
      end else if (mode < 9) begin
        repeat ($urandom_range(1, 5))
          queue_entry($urandom_range(0, 15), rand_entry($urandom_range(0, 2)), 1'b0);
        queue_entry($urandom_range(0, 15), rand_entry(0), 1'b1);
      end else begin
        queue_entry($urandom_range(0, 15), rand_entry(0), $urandom_range(0, 1));
      end
    end
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("sent %0d entries, %0d inversions (%0d singular), %0d inverse entries checked",
             entries_sent, inversions, singular_runs, results_seen);
    $display("%0d mismatches, %0d unexpected entries", mismatch_count, extra_count);
    if (mismatch_count == 0 && extra_count == 0 && expected_inverse.size() == 0) begin
      $display("affine_3d_inverse verification clean");
    end else begin
      $display("affine_3d_inverse verification failed");
    end
    $finish;
  end

endmodule
